### design/bced_pkg.sv
// Package for the button click event detector.
// Holds the widths, event codes, register indexes and reset values, and the button
// state and configuration structs. Has no dependencies.
package bced_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned RegWidth  = 24;
  localparam int unsigned IdxWidth  = 2;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_SINGLE = 2'd1,
    EVT_DOUBLE = 2'd2,
    EVT_LONG   = 2'd3
  } event_t;

  localparam logic [IdxWidth-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [IdxWidth-1:0] REG_DOUBLE_CLICK = 2'd1;
  localparam logic [IdxWidth-1:0] REG_LONG_PRESS   = 2'd2;

  localparam logic [RegWidth-1:0] DEBOUNCE_RESET     = 24'd5;
  localparam logic [RegWidth-1:0] DOUBLE_CLICK_RESET = 24'd4000;
  localparam logic [RegWidth-1:0] LONG_PRESS_RESET   = 24'd10000;

  typedef struct packed {
    logic                 level;
    logic [TimeWidth-1:0] press_time;
    logic                 long_inhibit;
  } btn_state_t;

  typedef struct packed {
    logic [RegWidth-1:0] debounce_ticks;
    logic [RegWidth-1:0] double_click_ticks;
    logic [RegWidth-1:0] long_press_ticks;
  } btn_cfg_t;

endpackage

### design/bced_decide.sv
// Decision logic for one poll: classifies the edge or hold and computes the next state.
// Depends on bced_pkg.
module bced_decide (
  input  bced_pkg::btn_state_t         state,
  input  bced_pkg::btn_cfg_t           cfg,
  input  logic [bced_pkg::TimeWidth-1:0] now_ticks,
  input  logic                         button_level,
  output bced_pkg::btn_state_t         state_next,
  output bced_pkg::event_t             event_code
);
  import bced_pkg::*;

  logic [TimeWidth-1:0] debounce_limit;
  logic [TimeWidth-1:0] double_limit;
  logic [TimeWidth-1:0] long_limit;
  logic                 debounce_done;
  logic                 double_done;
  logic                 long_done;

  // Sums wrap at the time width; the compares are plain unsigned compares.
  assign debounce_limit = state.press_time +
                          {{(TimeWidth-RegWidth){1'b0}}, cfg.debounce_ticks};
  assign double_limit   = state.press_time +
                          {{(TimeWidth-RegWidth){1'b0}}, cfg.double_click_ticks};
  assign long_limit     = state.press_time +
                          {{(TimeWidth-RegWidth){1'b0}}, cfg.long_press_ticks};
  assign debounce_done  = now_ticks >= debounce_limit;
  assign double_done    = now_ticks >= double_limit;
  assign long_done      = now_ticks >= long_limit;

  always_comb begin
    state_next       = state;
    state_next.level = button_level;
    event_code       = EVT_NONE;
    if (button_level != state.level) begin
      if (debounce_done) begin
        if (!button_level) begin
          if (state.long_inhibit) begin
            state_next.long_inhibit = 1'b0;
          end else begin
            event_code = EVT_SINGLE;
          end
        end else begin
          if (!double_done) begin
            event_code = EVT_DOUBLE;
          end else begin
            state_next.press_time = now_ticks;
          end
        end
      end
    end else if (button_level && !state.long_inhibit && long_done) begin
      event_code              = EVT_LONG;
      state_next.long_inhibit = 1'b1;
    end
  end

endmodule

### design/button_click_event_detector.sv
// Top level of the button click event detector.
// Depends on bced_pkg and bced_decide.
//
// Each input item is one poll of a push button: a 32-bit timestamp and the
// button level. Each poll yields exactly one result item holding an event
// code: none, single click, double click or long press.
// Polls enter on in_valid/in_stall and results leave on out_valid/out_stall.
// A poll is captured in an input register, decided combinationally and
// written to the result register when it advances. One poll per cycle is
// sustained while the receiver does not stall; the debounce,
// double-click and long-press compares sit between the two registers.
// When the receiver stalls, the result register holds its item, the input
// register still takes one more poll, and in_stall rises only when both are
// full. Reset clears the valid flags of both registers and the button
// state, and loads the configuration registers with their reset values.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// no poll is in flight; an index beyond the last register is ignored.
module button_click_event_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bced_pkg::IdxWidth-1:0]   cfg_index,
  input  logic [bced_pkg::RegWidth-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bced_pkg::TimeWidth-1:0]  now_ticks,
  input  logic                            button_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_code
);
  import bced_pkg::*;

  btn_cfg_t             cfg;
  btn_state_t           state;
  btn_state_t           state_next;
  event_t               decided_event;
  logic                 poll_valid;
  logic [TimeWidth-1:0] poll_time;
  logic                 poll_level;
  logic                 advance;

  assign advance  = poll_valid && (!out_valid || !out_stall);
  assign in_stall = poll_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.double_click_ticks <= DOUBLE_CLICK_RESET;
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      poll_valid <= 1'b1;
    end else if (advance) begin
      poll_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      poll_time  <= now_ticks;
      poll_level <= button_level;
    end
  end

  bced_decide u_decide (
    .state        (state),
    .cfg          (cfg),
    .now_ticks    (poll_time),
    .button_level (poll_level),
    .state_next   (state_next),
    .event_code   (decided_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code <= decided_event;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_poll: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> poll_valid && out_valid && out_stall)
    else $error("input stalled without a held poll and a stalled result");

  a_long_sets_inhibit: assert property (@(posedge clk) disable iff (rst)
    advance && decided_event == EVT_LONG |=> state.long_inhibit)
    else $error("long press did not set the inhibit flag");

  a_long_needs_hold: assert property (@(posedge clk) disable iff (rst)
    advance && decided_event == EVT_LONG |-> poll_level && state.level)
    else $error("long press reported without a held button");

  a_double_keeps_time: assert property (@(posedge clk) disable iff (rst)
    advance && decided_event == EVT_DOUBLE |=> $stable(state.press_time))
    else $error("double click changed the press time");
`endif

endmodule

### tb/tb_button_click_event_detector.sv
// Self-checking testbench for button_click_event_detector: polls stream in, event codes out.
// Predicts every event code from its own copy of the button state and registers.
// Depends on bced_pkg and the design files.
module tb_button_click_event_detector;
  import bced_pkg::*;

  localparam logic [IdxWidth-1:0] REG_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned NUM_PHASES = 9;

  typedef struct packed {
    logic [TimeWidth-1:0] stamp;
    logic                 level;
  } poll_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [IdxWidth-1:0]  cfg_index = '0;
  logic [RegWidth-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TimeWidth-1:0] now_ticks = '0;
  logic                 button_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           event_code;

  button_click_event_detector dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ticks    (now_ticks),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  btn_state_t           btn_state;
  btn_cfg_t             btn_cfg;
  poll_t                poll_queue[$];
  event_t               pending_events[$];
  poll_t                next_poll;
  event_t               want;
  int unsigned          send_gap = 0;
  int unsigned          recv_wait = 0;
  int unsigned          recv_draw;
  int unsigned          hold_left = 0;
  int unsigned          hold_requests = 0;
  int unsigned          holds_served = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          pace = 1;
  logic                 hold_sender = 1'b0;
  int unsigned          polls_queued = 0;
  int unsigned          polls_sent = 0;
  int unsigned          mismatches = 0;
  int unsigned          event_seen[4] = '{0, 0, 0, 0};
  logic [TimeWidth-1:0] t_gen = '0;
  logic                 gen_level = 1'b0;

  function automatic int unsigned draw_wait();
    case (pace)
      0: return 0;
      1: return $urandom_range(10, 0);
      default: return ($urandom_range(3, 0) == 0) ? $urandom_range(10, 1) : 0;
    endcase
  endfunction

  // All sums wrap at 32 bits and the compares are plain unsigned ones.
  function automatic event_t decide_event(input logic [TimeWidth-1:0] stamp, input logic lvl);
    event_t               ev;
    logic [TimeWidth-1:0] debounce_end;
    logic [TimeWidth-1:0] double_end;
    logic [TimeWidth-1:0] long_end;
    ev = EVT_NONE;
    debounce_end = btn_state.press_time + {8'd0, btn_cfg.debounce_ticks};
    double_end = btn_state.press_time + {8'd0, btn_cfg.double_click_ticks};
    long_end = btn_state.press_time + {8'd0, btn_cfg.long_press_ticks};
    if (lvl != btn_state.level) begin
      if (stamp >= debounce_end) begin
        if (!lvl) begin
          if (btn_state.long_inhibit) btn_state.long_inhibit = 1'b0;
          else ev = EVT_SINGLE;
        end else if (stamp < double_end) begin
          ev = EVT_DOUBLE;
        end else begin
          btn_state.press_time = stamp;
        end
      end
    end else if (lvl && !btn_state.long_inhibit && stamp >= long_end) begin
      ev = EVT_LONG;
      btn_state.long_inhibit = 1'b1;
    end
    btn_state.level = lvl;
    return ev;
  endfunction

  function automatic btn_cfg_t cfg_for_phase(input int unsigned p);
    case (p)
      0: return {24'd0, 24'hFFFFFF, 24'hFFFFFF};
      1: return {24'hFFFFFF, 24'd0, 24'd0};
      2: return {24'd3, 24'd50, 24'd120};
      3: return {24'd0, 24'd30, 24'd80};
      4: return {24'd8, 24'd300, 24'd900};
      5: return {24'd2, 24'd0, 24'd40};
      6: return {24'd20, 24'd10, 24'd50};
      7: return {DEBOUNCE_RESET, DOUBLE_CLICK_RESET, LONG_PRESS_RESET};
      default: return {24'($urandom_range(30, 0)), 24'($urandom_range(600, 0)),
                       24'($urandom_range(1500, 0))};
    endcase
  endfunction

  // Driver: offers queued polls and predicts the event of each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_events.push_back(decide_event(now_ticks, button_level));
        polls_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (poll_queue.size() != 0 && !hold_sender) begin
          next_poll = poll_queue.pop_front();
          in_valid <= 1'b1;
          now_ticks <= next_poll.stamp;
          button_level <= next_poll.level;
          send_gap <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: event_code %0d arrived with nothing expected", $time, event_code);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          event_seen[want]++;
          if (event_code !== want) begin
            $display("%0t: event_code expected %0d (%s), actual %0d", $time, want,
                     want.name(), event_code);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        holds_served <= holds_served + 1;
      end else if (out_valid && !out_stall) begin
        recv_draw = draw_wait();
        recv_wait <= recv_draw;
        out_stall <= (recv_draw != 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_stall <= (recv_wait > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [RegWidth-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DEBOUNCE:     btn_cfg.debounce_ticks = val;
      REG_DOUBLE_CLICK: btn_cfg.double_click_ticks = val;
      REG_LONG_PRESS:   btn_cfg.long_press_ticks = val;
      default: ;
    endcase
  endtask

  task automatic push_poll(input logic [TimeWidth-1:0] stamp, input logic lvl);
    poll_queue.push_back('{stamp: stamp, level: lvl});
    gen_level = lvl;
    polls_queued++;
  endtask

  task automatic step(input int unsigned lo, input int unsigned hi, input logic lvl);
    t_gen += $urandom_range(hi, lo);
    push_poll(t_gen, lvl);
  endtask

  task automatic drain();
    do @(negedge clk); while (poll_queue.size() != 0 || in_valid || pending_events.size() != 0);
  endtask

  // One gesture: mostly well-formed clicks, double clicks and holds, some bounce and noise.
  task automatic gesture();
    int unsigned db;
    int unsigned dc;
    int unsigned lp;
    db = btn_cfg.debounce_ticks;
    dc = btn_cfg.double_click_ticks;
    lp = btn_cfg.long_press_ticks;
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        step(dc, 2 * dc + db + 1, 1'b1);
        repeat ($urandom_range(3, 0)) step(0, db, 1'b1);
        step(db, dc + db, 1'b0);
      end
      3, 4: begin
        step(dc, 2 * dc + db + 1, 1'b1);
        step(db, db + dc / 3, 1'b0);
        step(0, dc / 3 + 1, 1'b1);
        step(0, dc / 2 + db, 1'b0);
      end
      5: begin
        step(dc, 2 * dc + db + 1, 1'b1);
        repeat ($urandom_range(6, 2)) step(0, lp / 2 + 1, 1'b1);
        step(0, 2 * db + 1, 1'b0);
      end
      6: repeat ($urandom_range(6, 2)) step(0, db, 1'($urandom_range(1, 0)));
      7: repeat ($urandom_range(4, 1)) step(0, 2 * lp + 1, 1'($urandom_range(1, 0)));
      8: begin
        if ($urandom_range(1, 0) == 1) t_gen = $urandom();
        else t_gen = 32'hFFFF_FFFF - $urandom_range(lp + dc + 2, 0);
        push_poll(t_gen, 1'($urandom_range(1, 0)));
      end
      default: repeat ($urandom_range(4, 1)) step(0, lp, gen_level);
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned quota;
    int unsigned start_count;
    btn_cfg_t    c;
    btn_state = '0;
    btn_cfg = {DEBOUNCE_RESET, DOUBLE_CLICK_RESET, LONG_PRESS_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: ignored edges, the early double click from a zero press
    // time, a third quick press, long press with its silent release, and
    // a long-press end that wraps past the top of the time counter.
    push_poll(32'd0, 1'b0);
    push_poll(32'd3, 1'b1);
    push_poll(32'd4, 1'b1);
    push_poll(32'd4, 1'b0);
    push_poll(32'd100, 1'b1);
    push_poll(32'd200, 1'b0);
    push_poll(32'd5000, 1'b1);
    push_poll(32'd5002, 1'b0);
    push_poll(32'd5010, 1'b1);
    push_poll(32'd5020, 1'b0);
    push_poll(32'd8999, 1'b1);
    push_poll(32'd15000, 1'b1);
    push_poll(32'd16000, 1'b1);
    push_poll(32'd16010, 1'b0);
    push_poll(32'hFFFF_F000, 1'b1);
    push_poll(32'hFFFF_F001, 1'b0);
    push_poll(32'h0000_0010, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b0);
    push_poll(32'h0000_0000, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b1);
    push_poll(32'h0000_0000, 1'b0);
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      c = cfg_for_phase(phase);
      write_reg(REG_DEBOUNCE, c.debounce_ticks);
      write_reg(REG_DOUBLE_CLICK, c.double_click_ticks);
      write_reg(REG_LONG_PRESS, c.long_press_ticks);
      if (phase == 0) write_reg(REG_SPARE, 24'($urandom()));
      @(negedge clk);
      pace = phase % 3;
      quota = (phase < 2) ? 15 : 85;
      start_count = polls_queued;
      while (polls_queued - start_count < quota) gesture();
      if (phase == 3 || phase == 6) hold_requests++;
      if (phase == 4 || phase == 7) begin
        while (poll_queue.size() > quota / 2) @(negedge clk);
        hold_sender = 1'b1;
        do @(negedge clk); while (in_valid || pending_events.size() != 0);
        hold_sender = 1'b0;
      end
      drain();
    end

    repeat (5) @(posedge clk);
    $display("Ran %0d polls through %0d register settings plus reset values.",
             polls_sent, NUM_PHASES);
    $display("Events seen: %0d none, %0d single, %0d double, %0d long press.",
             event_seen[EVT_NONE], event_seen[EVT_SINGLE], event_seen[EVT_DOUBLE],
             event_seen[EVT_LONG]);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/bced_pkg.sv
design/bced_decide.sv
design/button_click_event_detector.sv
tb/tb_button_click_event_detector.sv
